// ----- sv/dblc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dblc_pkg
// shared widths, request codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package dblc_pkg;

    localparam int SZ_W           = 7;    // size register
    localparam int SZ_MAX         = (1 << SZ_W) - 1;
    localparam int IDX_W          = 6;    // row / column index fields
    localparam int DIS_W          = 16;   // dissimilarity, unsigned q8.8
    localparam int SQ_W           = 32;   // squared entry, q16.16
    localparam int RS_W           = 38;   // row sum
    localparam int TOT_W          = 44;   // grand total
    localparam int DIVD_W         = 44;   // divider dividend
    localparam int DVS_W          = 14;   // divider divisor, holds n*n
    localparam int ACC_W          = 47;   // signed centering accumulator
    localparam int OUT_W          = 33;   // signed q16.16 result
    localparam int DIV_RADIX_BITS = 2;    // quotient bits per divider cycle

    localparam logic [SZ_W-1:0] SIZE_RESET = 7'd64;

    // request types
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_LOAD  = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // accumulator operations
    localparam logic [1:0] ACC_NONE = 2'd0;
    localparam logic [1:0] ACC_INIT = 2'd1;
    localparam logic [1:0] ACC_ADD  = 2'd2;
    localparam logic [1:0] ACC_SUB  = 2'd3;

    // divider operand sources
    localparam logic [1:0] DIV_SRC_RAM = 2'd0;
    localparam logic [1:0] DIV_SRC_RSB = 2'd1;
    localparam logic [1:0] DIV_SRC_TOT = 2'd2;

    typedef struct packed {
        logic       accept;
        logic       clear;
        logic       emit_err;
        logic       emit_ok;
        logic       ld_mul;
        logic       ld_write;
        logic       nn_load;
        logic       cap_d2;
        logic       cap_rsb;
        logic       rs_sel_col;
        logic       div_start;
        logic [1:0] div_src;
        logic [1:0] acc_op;
    } t_dp_cmd;

    typedef struct packed {
        logic in_range;
        logic diag;
        logic div_done;
    } t_dp_stat;

endpackage

// ----- sv/double_centering.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_centering
// double centering of a square dissimilarity matrix for classical scaling
// ----------------------------------------------------------------------------
// usage
//   an item is taken when start is high and busy is low; i_req_type picks
//   clear (row sums and total to zero), load (square one q8.8 entry, store it
//   and add it to its row sum and the total) or read (centered entry)
//   loads outside the size in use and diagonal loads are dropped
//   a read gives one result on o_centered_value / o_status, marked by o_valid
//   for exactly one cycle; the receiver cannot stall, so nothing waits
//   a read outside the size in use returns zero with status set, in the
//   cycle after it is taken, and busy stays low
// timing
//   clear: busy stays low
//   load: busy through squaring, then read-modify-write of the row sum
//   read: busy through the memory reads, then three divisions on the shared
//   serial divider (22 steps of two quotient bits plus a done pulse each,
//   the first overlapping the last read) and a final state to form the
//   result; the result shows in the first cycle with busy low, and a new
//   item may be taken in that cycle
// reset
//   size in use returns to 64, row-sum valid bits and the total clear at once;
//   the squared-entry memory holds garbage until loaded and needs no sweep
//   i_cfg_we writes the size register; write only while idle
// ----------------------------------------------------------------------------
module double_centering import dblc_pkg::*; #(
    parameter int MAX_N = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              i_req_type,
    input  logic [IDX_W-1:0]        i_row_index,
    input  logic [IDX_W-1:0]        i_col_index,
    input  logic [DIS_W-1:0]        i_dissimilarity,
    input  logic                    i_cfg_we,
    input  logic [SZ_W-1:0]         i_cfg_wdata,
    output logic                    o_valid,
    output logic signed [OUT_W-1:0] o_centered_value,
    output logic                    o_status
);

    // command and status between sequencer and datapath
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_busy;

    // sequencer: accepts items and steps loads and reads
    dblc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req_type),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_busy     (w_busy)
    );

    // datapath: memories, divider, accumulator and output register
    dblc_datapath #(
        .MAX_N (MAX_N)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_row_index      (i_row_index),
        .i_col_index      (i_col_index),
        .i_dissimilarity  (i_dissimilarity),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .o_centered_value (o_centered_value),
        .o_status         (o_status),
        .o_valid          (o_valid)
    );

    assign busy = w_busy;

endmodule

// ----- sv/dblc_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dblc_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module dblc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/dblc_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dblc_div
// serial restoring divider, DIV_RADIX_BITS quotient bits per cycle
// ----------------------------------------------------------------------------
module dblc_div import dblc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0]  i_divisor,
    output logic [DIVD_W-1:0] o_quotient,
    output logic              o_done
);

    localparam int STEPS = DIVD_W / DIV_RADIX_BITS;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [CNT_W-1:0]  r_cnt;
    logic              r_done;
    logic [DIVD_W-1:0] r_quo;
    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_dvs;

    logic [DIVD_W-1:0] n_quo;
    logic [DVS_W-1:0]  n_rem;
    logic [DVS_W:0]    w_trial;

    // dividend shifts out at the top, quotient bits shift in at the bottom
    always_comb begin
        n_quo   = r_quo;
        n_rem   = r_rem;
        w_trial = '0;
        for (int k = 0; k < DIV_RADIX_BITS; k++) begin
            w_trial = {n_rem, n_quo[DIVD_W-1]};
            n_quo   = {n_quo[DIVD_W-2:0], 1'b0};
            if (w_trial >= {1'b0, r_dvs}) begin
                w_trial  = w_trial - {1'b0, r_dvs};
                n_quo[0] = 1'b1;
            end
            n_rem = w_trial[DVS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(STEPS);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_cnt == '0))
        else $error("divider started while a division is running");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_cnt == '0))
        else $error("divider done with steps left");

    a_last_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == CNT_W'(1) && !i_start) |=> r_done)
        else $error("divider missed its done pulse");

endmodule

// ----- sv/dblc_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dblc_datapath
// squared store, row sums, total, shared divider and centering arithmetic
// ----------------------------------------------------------------------------
module dblc_datapath import dblc_pkg::*; #(
    parameter int MAX_N = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [SZ_W-1:0]         i_cfg_wdata,
    input  logic [IDX_W-1:0]        i_row_index,
    input  logic [IDX_W-1:0]        i_col_index,
    input  logic [DIS_W-1:0]        i_dissimilarity,
    input  t_dp_cmd                 i_cmd,
    output t_dp_stat                o_stat,
    output logic signed [OUT_W-1:0] o_centered_value,
    output logic                    o_status,
    output logic                    o_valid
);

    localparam int IW  = $clog2(MAX_N);
    localparam int XW  = (IW > IDX_W) ? IW : IDX_W;
    localparam int AW  = $clog2(MAX_N * MAX_N);
    localparam int CAP = (MAX_N > SZ_MAX) ? SZ_MAX : MAX_N;

    // configuration and captured item
    logic [SZ_W-1:0]  r_size;
    logic [SZ_W-1:0]  w_n_eff;
    logic [IDX_W-1:0] r_row;
    logic [IDX_W-1:0] r_col;
    logic [DIS_W-1:0] r_dis;
    logic             r_diag;

    logic [XW-1:0]    w_row_x;
    logic [XW-1:0]    w_col_x;
    logic [IW-1:0]    w_row_i;
    logic [IW-1:0]    w_col_i;
    logic [AW-1:0]    w_sq_addr;

    // load path
    logic [SQ_W-1:0]  r_sq;
    logic [SQ_W-1:0]  w_sq_rdata;
    logic [RS_W-1:0]  w_rs_rdata;
    logic [RS_W-1:0]  w_rs_rd;
    logic [RS_W-1:0]  w_rs_new;
    logic [IW-1:0]    w_rs_raddr;
    logic [MAX_N-1:0] r_rs_valid;
    logic             r_vld_rd;
    logic [TOT_W-1:0] r_total;

    // read path
    logic [SQ_W-1:0]         r_d2;
    logic [RS_W-1:0]         r_rs_b;
    logic [DVS_W-1:0]        r_nn;
    logic [DIVD_W-1:0]       w_dividend;
    logic [DVS_W-1:0]        w_divisor;
    logic [DIVD_W-1:0]       w_quo;
    logic                    w_div_done;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] w_q_ext;
    logic signed [ACC_W-1:0] w_d2_ext;
    logic signed [ACC_W-1:0] w_half;
    logic signed [OUT_W-1:0] w_sat;
    logic                    w_fits;

    // output register
    logic                    r_out_valid;
    logic                    r_out_status;
    logic signed [OUT_W-1:0] r_out_value;

    // sizes above the store act as the store size
    assign w_n_eff = (int'(r_size) > CAP) ? SZ_W'(CAP) : r_size;

    assign o_stat.in_range = ({1'b0, i_row_index} < w_n_eff) &&
                             ({1'b0, i_col_index} < w_n_eff);
    assign o_stat.diag     = (i_row_index == i_col_index);
    assign o_stat.div_done = w_div_done;

    assign w_row_x   = XW'(r_row);
    assign w_col_x   = XW'(r_col);
    assign w_row_i   = w_row_x[IW-1:0];
    assign w_col_i   = w_col_x[IW-1:0];
    assign w_sq_addr = AW'(int'(w_row_i) * MAX_N + int'(w_col_i));

    assign w_rs_raddr = i_cmd.rs_sel_col ? w_col_i : w_row_i;
    assign w_rs_rd    = r_vld_rd ? w_rs_rdata : '0;
    assign w_rs_new   = w_rs_rd + RS_W'(r_sq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size      <= SIZE_RESET;
            r_rs_valid  <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_size <= i_cfg_wdata;
            end
            if (i_cmd.clear) begin
                r_rs_valid <= '0;
                r_total    <= '0;
            end else if (i_cmd.ld_write) begin
                r_rs_valid[w_row_i] <= 1'b1;
                r_total             <= r_total + TOT_W'(r_sq);
            end
            r_out_valid <= i_cmd.emit_ok || i_cmd.emit_err;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vld_rd <= r_rs_valid[w_rs_raddr];
        if (i_cmd.accept) begin
            r_row  <= i_row_index;
            r_col  <= i_col_index;
            r_dis  <= i_dissimilarity;
            r_diag <= (i_row_index == i_col_index);
        end
        if (i_cmd.ld_mul) begin
            r_sq <= SQ_W'(r_dis) * SQ_W'(r_dis);
        end
        if (i_cmd.nn_load) begin
            r_nn <= DVS_W'(w_n_eff) * DVS_W'(w_n_eff);
        end
        if (i_cmd.cap_d2) begin
            r_d2 <= r_diag ? '0 : w_sq_rdata;
        end
        if (i_cmd.cap_rsb) begin
            r_rs_b <= w_rs_rd;
        end
    end

    dblc_ram #(
        .WIDTH (SQ_W),
        .DEPTH (MAX_N * MAX_N)
    ) u_sq_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ld_write),
        .i_waddr (w_sq_addr),
        .i_wdata (r_sq),
        .i_raddr (w_sq_addr),
        .o_rdata (w_sq_rdata)
    );

    dblc_ram #(
        .WIDTH (RS_W),
        .DEPTH (MAX_N)
    ) u_rs_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ld_write),
        .i_waddr (w_row_i),
        .i_wdata (w_rs_new),
        .i_raddr (w_rs_raddr),
        .o_rdata (w_rs_rdata)
    );

    always_comb begin
        case (i_cmd.div_src)
            DIV_SRC_RAM: begin
                w_dividend = DIVD_W'(w_rs_rd);
                w_divisor  = DVS_W'(w_n_eff);
            end
            DIV_SRC_RSB: begin
                w_dividend = DIVD_W'(r_rs_b);
                w_divisor  = DVS_W'(w_n_eff);
            end
            DIV_SRC_TOT: begin
                w_dividend = r_total;
                w_divisor  = r_nn;
            end
            default: begin
                w_dividend = r_total;
                w_divisor  = r_nn;
            end
        endcase
    end

    dblc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_quotient (w_quo),
        .o_done     (w_div_done)
    );

    // accumulate the negated sum: ri - d2, + rj, - t
    assign w_q_ext  = $signed({{(ACC_W-DIVD_W){1'b0}}, w_quo});
    assign w_d2_ext = $signed({{(ACC_W-SQ_W){1'b0}}, r_d2});

    always_ff @(posedge i_clk) begin
        case (i_cmd.acc_op)
            ACC_INIT: r_acc <= w_q_ext - w_d2_ext;
            ACC_ADD:  r_acc <= r_acc + w_q_ext;
            ACC_SUB:  r_acc <= r_acc - w_q_ext;
            default:  r_acc <= r_acc;
        endcase
    end

    // floor halving, then clamp to the result range
    assign w_half = r_acc >>> 1;
    assign w_fits = (&w_half[ACC_W-1:OUT_W-1]) || !(|w_half[ACC_W-1:OUT_W-1]);
    assign w_sat  = w_fits ? w_half[OUT_W-1:0] :
                    w_half[ACC_W-1] ? $signed({1'b1, {(OUT_W-1){1'b0}}}) :
                                      $signed({1'b0, {(OUT_W-1){1'b1}}});

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_err) begin
            r_out_value  <= '0;
            r_out_status <= 1'b1;
        end else if (i_cmd.emit_ok) begin
            r_out_value  <= w_sat;
            r_out_status <= 1'b0;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_out_status;
    assign o_centered_value = r_out_value;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status) |-> (r_out_value == '0))
        else $error("flagged item carries a nonzero value");

    a_one_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.emit_ok && i_cmd.emit_err))
        else $error("two results emitted in one cycle");

    a_write_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ld_write |-> $past(i_cmd.ld_mul))
        else $error("load written without a fresh square");

endmodule

// ----- sv/dblc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dblc_ctrl
// request sequencer for loads, reads and clears
// ----------------------------------------------------------------------------
module dblc_ctrl import dblc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_req_type,
    input  t_dp_stat   i_stat,
    output t_dp_cmd    o_cmd,
    output logic       o_busy
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_LD0  = 4'd1;
    localparam logic [3:0] S_LD1  = 4'd2;
    localparam logic [3:0] S_RD0  = 4'd3;
    localparam logic [3:0] S_RD1  = 4'd4;
    localparam logic [3:0] S_RD2  = 4'd5;
    localparam logic [3:0] S_DIV1 = 4'd6;
    localparam logic [3:0] S_DIV2 = 4'd7;
    localparam logic [3:0] S_DIV3 = 4'd8;
    localparam logic [3:0] S_FIN  = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    case (i_req_type)
                        REQ_START: o_cmd.clear = 1'b1;
                        REQ_LOAD: begin
                            if (i_stat.in_range && !i_stat.diag) begin
                                n_state = S_LD0;
                            end
                        end
                        REQ_READ: begin
                            if (i_stat.in_range) begin
                                n_state = S_RD0;
                            end else begin
                                o_cmd.emit_err = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_LD0: begin
                o_cmd.ld_mul = 1'b1;
                n_state      = S_LD1;
            end
            S_LD1: begin
                o_cmd.ld_write = 1'b1;
                n_state        = S_IDLE;
            end
            S_RD0: begin
                o_cmd.nn_load = 1'b1;
                n_state       = S_RD1;
            end
            S_RD1: begin
                o_cmd.cap_d2     = 1'b1;
                o_cmd.div_start  = 1'b1;
                o_cmd.div_src    = DIV_SRC_RAM;
                o_cmd.rs_sel_col = 1'b1;
                n_state          = S_RD2;
            end
            S_RD2: begin
                o_cmd.cap_rsb = 1'b1;
                n_state       = S_DIV1;
            end
            S_DIV1: begin
                if (i_stat.div_done) begin
                    o_cmd.acc_op    = ACC_INIT;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_src   = DIV_SRC_RSB;
                    n_state         = S_DIV2;
                end
            end
            S_DIV2: begin
                if (i_stat.div_done) begin
                    o_cmd.acc_op    = ACC_ADD;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_src   = DIV_SRC_TOT;
                    n_state         = S_DIV3;
                end
            end
            S_DIV3: begin
                if (i_stat.div_done) begin
                    o_cmd.acc_op = ACC_SUB;
                    n_state      = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.emit_ok = 1'b1;
                n_state       = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for double_centering: a directed table, a row-sum wrap
// and saturation stress, then random phases at many matrix sizes, each result
// checked field by field against the table or a bench-side centering predictor
// ----------------------------------------------------------------------------
module tb;
    import dblc_pkg::*;

    localparam int          MAX_N        = 64;
    localparam logic [1:0]  REQ_IGNORED  = 2'd3;    // request type three, dropped
    localparam logic        ST_OK        = 1'b0;
    localparam logic        ST_RANGE     = 1'b1;    // index outside size in use
    localparam int          USEFUL_ITEMS = 1150;
    localparam int          MAX_GAP      = 12;
    localparam int          LOAD_SETTLE  = 8;       // settle time; a load finishes after its squaring and write states
    localparam int          READ_LATENCY = 80;      // covers a read's busy time plus the output stage
    localparam longint      OUT_HI       = 64'sd4294967295;
    localparam longint      OUT_LO       = -64'sd4294967296;

    typedef enum logic {STEP_REQ, STEP_SIZE} t_step_kind;

    typedef struct packed {
        logic signed [OUT_W-1:0] value;
        logic                    status;
    } t_centered;

    // one row of the directed table; value/status only used when known is set
    typedef struct packed {
        t_step_kind              kind;
        logic [1:0]              req;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic [DIS_W-1:0]        dis;
        logic [SZ_W-1:0]         size;
        logic                    known;
        logic signed [OUT_W-1:0] value;
        logic                    status;
    } t_plan_row;

    // dut connections, all known from time zero
    logic                    i_clk           = 1'b0;
    logic                    i_rst_n         = 1'b0;
    logic                    start           = 1'b0;
    logic                    busy;
    logic [1:0]              i_req_type      = REQ_START;
    logic [IDX_W-1:0]        i_row_index     = '0;
    logic [IDX_W-1:0]        i_col_index     = '0;
    logic [DIS_W-1:0]        i_dissimilarity = '0;
    logic                    i_cfg_we        = 1'b0;
    logic [SZ_W-1:0]         i_cfg_wdata     = '0;
    logic                    o_valid;
    logic signed [OUT_W-1:0] o_centered_value;
    logic                    o_status;

    // predictor state: squared store, row sums, total and size register
    logic [SQ_W-1:0]  sq_mem [0:MAX_N*MAX_N-1];
    bit               written [0:MAX_N*MAX_N-1];
    logic [RS_W-1:0]  row_acc [0:MAX_N-1];
    logic [TOT_W-1:0] grand_total;
    logic [SZ_W-1:0]  size_reg;

    t_centered centered_due [$];    // centered results still owed by the dut
    t_centered oldest;
    t_plan_row plan [$];

    bit quiet_sender = 1'b0;        // no idle cycles between items
    int mismatches   = 0;
    int checked      = 0;
    int taken_items  = 0;
    int effective    = 0;           // items the block does not drop
    int size_writes  = 0;

    always #2 i_clk = ~i_clk;

    double_centering #(.MAX_N(MAX_N)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_req_type      (i_req_type),
        .i_row_index     (i_row_index),
        .i_col_index     (i_col_index),
        .i_dissimilarity (i_dissimilarity),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_valid         (o_valid),
        .o_centered_value(o_centered_value),
        .o_status        (o_status)
    );

    // sizes above MAX_N behave as MAX_N, zero leaves every index outside
    function automatic int eff_size();
        return (size_reg > MAX_N) ? MAX_N : int'(size_reg);
    endfunction

    // updates the predictor for one taken item; returns 1 unless the item is dropped
    function automatic bit predict_request(input logic [1:0] req,
                                           input logic [IDX_W-1:0] row,
                                           input logic [IDX_W-1:0] col,
                                           input logic [DIS_W-1:0] dis,
                                           output bit gives,
                                           output t_centered res);
        longint unsigned n, d2, ri, rj, tq;
        longint          v, y;
        logic [SQ_W-1:0] sq;
        bit              in_range;
        n        = eff_size();
        in_range = (row < n) && (col < n);
        gives    = 1'b0;
        res      = '0;
        case (req)
            REQ_START: begin
                for (int k = 0; k < MAX_N; k++) row_acc[k] = '0;
                grand_total = '0;
                return 1'b1;
            end
            REQ_LOAD: begin
                if (!in_range || row == col) return 1'b0;
                sq = {16'd0, dis} * {16'd0, dis};
                sq_mem[{row, col}]  = sq;
                written[{row, col}] = 1'b1;
                row_acc[row] = row_acc[row] + sq;   // wraps at 38 bits
                grand_total  = grand_total + sq;    // wraps at 44 bits
                return 1'b1;
            end
            REQ_READ: begin
                gives = 1'b1;
                if (!in_range) begin
                    res.status = ST_RANGE;
                    return 1'b1;
                end
                d2 = (row == col) ? 64'd0 : 64'(sq_mem[{row, col}]);
                ri = row_acc[row] / n;
                rj = row_acc[col] / n;
                tq = grand_total / (n * n);
                v  = longint'(d2) - longint'(ri) - longint'(rj) + longint'(tq);
                // halving rounds toward minus infinity
                y  = (-v) >>> 1;
                if (y > OUT_HI) y = OUT_HI;
                else if (y < OUT_LO) y = OUT_LO;
                res.value  = y[OUT_W-1:0];
                res.status = ST_OK;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // hands one item over and books what it should produce
    task automatic issue(input logic [1:0] req, input int row, input int col, input int dis,
                         input bit known, input t_centered known_res);
        int        gap;
        bit        gives;
        t_centered res;
        gap = quiet_sender ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_req_type      <= req;
        i_row_index     <= row[IDX_W-1:0];
        i_col_index     <= col[IDX_W-1:0];
        i_dissimilarity <= dis[DIS_W-1:0];
        // taken at the first edge with start high and busy low
        do @(posedge i_clk); while (busy !== 1'b0);
        if (predict_request(req, row[IDX_W-1:0], col[IDX_W-1:0], dis[DIS_W-1:0],
                            gives, res)) effective++;
        if (gives) centered_due.push_back(known ? known_res : res);
        taken_items++;
    endtask

    // size register is written only with the block idle and nothing owed
    task automatic write_size(input int size);
        start <= 1'b0;
        while (centered_due.size() != 0 || busy !== 1'b0) @(posedge i_clk);
        // a load gives no result and may still be finishing
        repeat (LOAD_SETTLE) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= size[SZ_W-1:0];
        @(posedge i_clk);
        size_reg = size[SZ_W-1:0];
        i_cfg_we <= 1'b0;
        size_writes++;
    endtask

    function automatic logic [DIS_W-1:0] draw_dissimilarity();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return DIS_W'($urandom);
        endcase
    endfunction

    function automatic void plan_item(input logic [1:0] req, input int row, input int col,
                                      input int dis);
        t_plan_row p;
        p      = '0;
        p.kind = STEP_REQ;
        p.req  = req;
        p.row  = row[IDX_W-1:0];
        p.col  = col[IDX_W-1:0];
        p.dis  = dis[DIS_W-1:0];
        plan.push_back(p);
    endfunction

    // read whose result is plain from the current contents
    function automatic void plan_known(input int row, input int col,
                                       input logic signed [OUT_W-1:0] value, input logic st);
        t_plan_row p;
        p        = '0;
        p.kind   = STEP_REQ;
        p.req    = REQ_READ;
        p.row    = row[IDX_W-1:0];
        p.col    = col[IDX_W-1:0];
        p.known  = 1'b1;
        p.value  = value;
        p.status = st;
        plan.push_back(p);
    endfunction

    function automatic void plan_size(input int size);
        t_plan_row p;
        p      = '0;
        p.kind = STEP_SIZE;
        p.size = size[SZ_W-1:0];
        plan.push_back(p);
    endfunction

    // one random phase: new size, clear, then mostly well-formed load/read traffic
    task automatic run_phase(input int size, input int count);
        int n, pick, row, col, idx;
        int loaded_rc [$];      // entries loaded during this phase
        write_size(size);
        quiet_sender = ($urandom_range(0, 3) == 0);
        n = eff_size();
        issue(REQ_START, $urandom_range(0, 63), $urandom_range(0, 63), $urandom, 1'b0, '0);
        repeat (count) begin
            pick = $urandom_range(0, 99);
            row  = $urandom_range(0, 63);
            col  = $urandom_range(0, 63);
            if (pick < 45 && n >= 2) begin
                // off-diagonal load inside the size in use
                row = $urandom_range(0, n - 1);
                col = (row + $urandom_range(1, n - 1)) % n;
                loaded_rc.push_back(row * MAX_N + col);
                issue(REQ_LOAD, row, col, int'(draw_dissimilarity()), 1'b0, '0);
            end else if (pick < 78 && n >= 1) begin
                // read of a loaded entry or of the diagonal, never of garbage
                if (loaded_rc.size() != 0 && $urandom_range(0, 1)) begin
                    idx = loaded_rc[$urandom_range(0, loaded_rc.size() - 1)];
                    row = idx / MAX_N;
                    col = idx % MAX_N;
                end else begin
                    row = $urandom_range(0, n - 1);
                    col = $urandom_range(0, n - 1);
                    if (!written[row * MAX_N + col]) col = row;
                end
                issue(REQ_READ, row, col, $urandom, 1'b0, '0);
            end else if (pick < 84) begin
                // read outside the size in use, diagonal when every index fits
                if (n >= MAX_N) col = row;
                else if ($urandom_range(0, 1)) row = $urandom_range(n, 63);
                else col = $urandom_range(n, 63);
                issue(REQ_READ, row, col, $urandom, 1'b0, '0);
            end else if (pick < 90) begin
                // load the block drops: outside or on the diagonal
                if (n < MAX_N && $urandom_range(0, 1)) row = $urandom_range(n, 63);
                else col = row;
                issue(REQ_LOAD, row, col, int'(draw_dissimilarity()), 1'b0, '0);
            end else if (pick < 93) begin
                issue(REQ_IGNORED, row, col, $urandom, 1'b0, '0);
            end else if (pick < 96) begin
                issue(REQ_START, row, col, $urandom, 1'b0, '0);
            end else begin
                // load anywhere, inside or not
                issue(REQ_LOAD, row, col, int'(draw_dissimilarity()), 1'b0, '0);
            end
        end
    endtask

    // result checker: the dut cannot be stalled, so every strobe is a result
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid !== 1'b0) begin
            if (centered_due.size() == 0) begin
                $display("%0t: unexpected result, value %0d status %0b",
                         $time, o_centered_value, o_status);
                mismatches++;
            end else begin
                oldest = centered_due.pop_front();
                if (o_centered_value !== oldest.value) begin
                    $display("%0t: centered_value expected %0d actual %0d",
                             $time, oldest.value, o_centered_value);
                    mismatches++;
                end
                if (o_status !== oldest.status) begin
                    $display("%0t: status expected %0b actual %0b",
                             $time, oldest.status, o_status);
                    mismatches++;
                end
                checked++;
            end
        end
    end

    // hard stop in case the dut hangs
    initial begin
        #2_000_000;
        $display("%0t: timeout, %0d results still owed", $time, centered_due.size());
        $display("Verification failed");
        $finish;
    end

    initial begin
        t_plan_row p;
        t_centered typed;
        int        size;

        // predictor starts from the reset state; the store counts as unwritten
        for (int k = 0; k < MAX_N; k++) row_acc[k] = '0;
        for (int k = 0; k < MAX_N * MAX_N; k++) written[k] = 1'b0;
        grand_total = '0;
        size_reg    = SIZE_RESET;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        plan_known(0, 0, '0, ST_OK);            // all sums zero after reset
        plan_known(63, 63, '0, ST_OK);          // far corner of the full size
        plan_item(REQ_IGNORED, 63, 0, 'hFFFF);  // type three, no result
        plan_item(REQ_LOAD, 0, 0, 'hFFFF);      // diagonal load, dropped
        plan_item(REQ_LOAD, 0, 1, 'hFFFF);      // largest square
        plan_item(REQ_LOAD, 1, 0, 'h0000);
        plan_item(REQ_LOAD, 63, 62, 'h0001);
        plan_item(REQ_LOAD, 62, 63, 'h8000);
        plan_item(REQ_READ, 0, 1, 0);
        plan_item(REQ_READ, 1, 0, 0);
        plan_item(REQ_READ, 0, 0, 0);
        plan_item(REQ_READ, 62, 63, 0);
        plan_item(REQ_READ, 63, 62, 0);
        plan_item(REQ_START, 63, 63, 'hFFFF);   // clears sums, store is kept
        plan_known(0, 1, -33'sd2147418113, ST_OK);  // -(ffff^2)/2 rounded down
        plan_size(2);
        plan_known(2, 0, '0, ST_RANGE);
        plan_known(0, 63, '0, ST_RANGE);
        plan_item(REQ_LOAD, 3, 1, 'h1234);      // outside, dropped
        plan_size(0);                           // nothing is in range
        plan_known(0, 0, '0, ST_RANGE);
        plan_item(REQ_LOAD, 0, 1, 'hFFFF);
        plan_size(SZ_MAX);                      // acts as the full size
        plan_item(REQ_READ, 0, 1, 0);
        plan_size(1);
        plan_known(0, 0, '0, ST_OK);
        plan_known(0, 1, '0, ST_RANGE);
        plan_size(MAX_N);

        foreach (plan[k]) begin
            p = plan[k];
            typed.value  = p.value;
            typed.status = p.status;
            if (p.kind == STEP_SIZE) write_size(int'(p.size));
            else issue(p.req, int'(p.row), int'(p.col), int'(p.dis), p.known, typed);
        end

        // size two: one row sum grows past 2^38 and wraps while the total
        // keeps going, driving the result to both saturation limits
        write_size(2);
        quiet_sender = 1'b1;
        issue(REQ_START, 0, 0, 0, 1'b0, '0);
        for (int k = 0; k < 90; k++) begin
            issue(REQ_LOAD, 0, 1, $urandom_range(16'hFF00, 16'hFFFF), 1'b0, '0);
            if (k % 6 == 5)
                issue(REQ_READ, ((k / 6) >> 1) & 1, (k / 6) & 1, 0, 1'b0, '0);
        end

        // random phases, the register extremes first
        run_phase(MAX_N, 60);
        run_phase(1, 20);
        run_phase(2, 40);
        run_phase(0, 20);
        run_phase(SZ_MAX, 60);
        while (taken_items < USEFUL_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       size = 0;
                1:       size = 1;
                2:       size = MAX_N;
                3:       size = $urandom_range(MAX_N + 1, SZ_MAX);
                4, 5:    size = $urandom_range(2, MAX_N);
                default: size = $urandom_range(2, 12);  // small sizes reach loaded entries
            endcase
            run_phase(size, $urandom_range(20, 80));
        end
        start <= 1'b0;

        // drain, then watch a while for stray results
        while (centered_due.size() != 0) @(posedge i_clk);
        repeat (READ_LATENCY) @(posedge i_clk);

        $display("run covered %0d items (%0d not dropped) over %0d size writes, sizes 0 to %0d",
                 taken_items, effective, size_writes, SZ_MAX);
        $display("%0d centered results checked, %0d mismatches", checked, mismatches);
        if (mismatches == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

endmodule
